// File: hw/rtl/dfcq_pkg.sv
// Shared constants, codes and controller/datapath interface types of the frame command queue.
`default_nettype none

package dfcq_pkg;

  localparam int unsigned MaxCmdLen  = 32;
  localparam int unsigned AsmBytes   = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned ResultCap  = 31;

  localparam logic [7:0] Terminator = 8'h21;

  localparam int unsigned FrameLimit =
      ((MaxCmdLen < AsmBytes) ? MaxCmdLen : AsmBytes) - 1;
  localparam int unsigned FillW     = $clog2(FrameLimit + 1);
  localparam int unsigned AsmIdxW   = $clog2(AsmBytes);
  localparam int unsigned SlotW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW    = $clog2(QueueDepth + 1);
  localparam int unsigned QmemDepth = QueueDepth * MaxCmdLen;
  localparam int unsigned QAddrW    = $clog2(QmemDepth);

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PS_IDLE      = 2'd0,
    PS_RECEIVING = 2'd1,
    PS_PENDING   = 2'd2
  } parse_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_COMMIT,
    ST_EMIT,
    ST_POP_RD,
    ST_POP_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic  latch;
    logic  rx_store;
    logic  rx_overflow;
    logic  end_discard;
    logic  drop_frame;
    logic  copy_step;
    logic  commit;
    logic  pop_start;
    logic  pop_read;
    logic  pop_next;
    logic  clear;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       is_term;
    logic       discarding;
    logic       fill_zero;
    logic       fill_full;
    logic       queue_full;
    logic       queue_empty;
    logic       copy_zero;
    logic       copy_last;
    logic       pop_last;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/dfcq_datapath.sv
// Datapath of the frame command queue: buffers, queue memory, pointers, counters and result register.
`default_nettype none

module dfcq_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           op_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic [7:0]           out_limit_i,
  input  wire logic                 out_stall_i,
  input  wire dfcq_pkg::dp_cmd_t    cmd_i,
  output dfcq_pkg::dp_status_t      status_o,
  output logic                      out_valid_o,
  output logic [1:0]                kind_o,
  output logic [7:0]                data_byte_o,
  output logic [4:0]                cmd_length_o,
  output logic                      is_last_o,
  output logic [1:0]                parse_state_o,
  output logic [2:0]                queue_count_o,
  output logic [31:0]               frame_overflows_o,
  output logic [31:0]               queue_overflows_o
);

  logic [7:0] abuf_mem [dfcq_pkg::AsmBytes];
  logic [7:0] qmem     [dfcq_pkg::QmemDepth];

  logic [1:0] op_q;
  logic [7:0] byte_q;
  logic [7:0] limit_q;

  logic [dfcq_pkg::FillW-1:0]  fill_q, fill_d;
  logic                        disc_q, disc_d;
  dfcq_pkg::parse_state_e      pstate_q, pstate_d;
  logic [dfcq_pkg::FillW-1:0]  slot_len_q [dfcq_pkg::QueueDepth];
  logic [dfcq_pkg::SlotW-1:0]  rp_q, rp_d;
  logic [dfcq_pkg::SlotW-1:0]  wp_q, wp_d;
  logic [dfcq_pkg::CountW-1:0] count_q, count_d;
  logic [31:0]                 fovf_q, fovf_d;
  logic [31:0]                 qovf_q, qovf_d;

  logic [dfcq_pkg::FillW-1:0]  cp_idx_q;
  logic [dfcq_pkg::FillW-1:0]  wr_idx_q;
  logic                        wr_pend_q;
  logic [7:0]                  abuf_rdata_q;

  logic [dfcq_pkg::SlotW-1:0]  pop_slot_q;
  logic [dfcq_pkg::FillW-1:0]  pop_len_q;
  logic [dfcq_pkg::FillW-1:0]  pop_copy_q;
  logic [dfcq_pkg::FillW-1:0]  pop_idx_q;
  logic [7:0]                  qrdata_q;

  logic                        out_valid_q;
  dfcq_pkg::kind_e             out_kind_q;
  logic [7:0]                  out_data_q;
  logic [4:0]                  out_len_q;
  logic                        out_last_q;
  logic [1:0]                  out_pstate_q;
  logic [2:0]                  out_count_q;
  logic [31:0]                 out_fovf_q;
  logic [31:0]                 out_qovf_q;

  logic [dfcq_pkg::FillW-1:0]  head_len;
  logic [8:0]                  copy_w;
  logic [dfcq_pkg::QAddrW-1:0] wr_addr;
  logic [dfcq_pkg::QAddrW-1:0] rd_addr;
  logic [dfcq_pkg::SlotW-1:0]  rp_next;
  logic [dfcq_pkg::SlotW-1:0]  wp_next;
  logic [dfcq_pkg::CountW-1:0] count_dec;

  assign head_len = slot_len_q[rp_q];

  always_comb begin
    copy_w = 9'd0;
    if (limit_q != 8'd0) begin
      if (9'(head_len) >= 9'(limit_q)) begin
        copy_w = 9'(limit_q) - 9'd1;
      end else begin
        copy_w = 9'(head_len);
      end
    end
    if (copy_w > 9'(dfcq_pkg::ResultCap)) begin
      copy_w = 9'(dfcq_pkg::ResultCap);
    end
    if (copy_w > 9'(dfcq_pkg::MaxCmdLen)) begin
      copy_w = 9'(dfcq_pkg::MaxCmdLen);
    end
  end

  assign rp_next   = (rp_q == dfcq_pkg::SlotW'(dfcq_pkg::QueueDepth - 1)) ?
                     '0 : rp_q + 1'b1;
  assign wp_next   = (wp_q == dfcq_pkg::SlotW'(dfcq_pkg::QueueDepth - 1)) ?
                     '0 : wp_q + 1'b1;
  assign count_dec = count_q - 1'b1;

  assign wr_addr = dfcq_pkg::QAddrW'(wp_q) * dfcq_pkg::QAddrW'(dfcq_pkg::MaxCmdLen)
                 + dfcq_pkg::QAddrW'(wr_idx_q);
  assign rd_addr = dfcq_pkg::QAddrW'(pop_slot_q) * dfcq_pkg::QAddrW'(dfcq_pkg::MaxCmdLen)
                 + dfcq_pkg::QAddrW'(pop_idx_q);

  always_comb begin
    fill_d   = fill_q;
    disc_d   = disc_q;
    pstate_d = pstate_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    count_d  = count_q;
    fovf_d   = fovf_q;
    qovf_d   = qovf_q;
    if (cmd_i.rx_store) begin
      fill_d   = fill_q + 1'b1;
      pstate_d = dfcq_pkg::PS_RECEIVING;
    end
    if (cmd_i.rx_overflow) begin
      fill_d   = '0;
      disc_d   = 1'b1;
      fovf_d   = fovf_q + 32'd1;
      pstate_d = dfcq_pkg::PS_RECEIVING;
    end
    if (cmd_i.end_discard) begin
      fill_d   = '0;
      disc_d   = 1'b0;
      pstate_d = (count_q != '0) ? dfcq_pkg::PS_PENDING : dfcq_pkg::PS_IDLE;
    end
    if (cmd_i.drop_frame) begin
      fill_d = '0;
      qovf_d = qovf_q + 32'd1;
    end
    if (cmd_i.commit) begin
      fill_d   = '0;
      wp_d     = wp_next;
      count_d  = count_q + 1'b1;
      pstate_d = dfcq_pkg::PS_PENDING;
    end
    if (cmd_i.pop_start) begin
      rp_d     = rp_next;
      count_d  = count_dec;
      pstate_d = (count_dec != '0) ? dfcq_pkg::PS_PENDING : dfcq_pkg::PS_IDLE;
    end
    if (cmd_i.clear) begin
      fill_d   = '0;
      disc_d   = 1'b0;
      pstate_d = dfcq_pkg::PS_IDLE;
      rp_d     = '0;
      wp_d     = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      disc_q    <= 1'b0;
      pstate_q  <= dfcq_pkg::PS_IDLE;
      rp_q      <= '0;
      wp_q      <= '0;
      count_q   <= '0;
      fovf_q    <= '0;
      qovf_q    <= '0;
      wr_pend_q <= 1'b0;
      cp_idx_q  <= '0;
      for (int i = 0; i < dfcq_pkg::QueueDepth; i++) begin
        slot_len_q[i] <= '0;
      end
    end else begin
      fill_q    <= fill_d;
      disc_q    <= disc_d;
      pstate_q  <= pstate_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      count_q   <= count_d;
      fovf_q    <= fovf_d;
      qovf_q    <= qovf_d;
      wr_pend_q <= cmd_i.copy_step;
      if (cmd_i.latch) begin
        cp_idx_q <= '0;
      end else if (cmd_i.copy_step) begin
        cp_idx_q <= cp_idx_q + 1'b1;
      end
      if (cmd_i.commit) begin
        slot_len_q[wp_q] <= fill_q;
      end
      if (cmd_i.pop_start) begin
        slot_len_q[rp_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_i;
      byte_q  <= rx_byte_i;
      limit_q <= out_limit_i;
    end
    if (cmd_i.rx_store) begin
      abuf_mem[dfcq_pkg::AsmIdxW'(fill_q)] <= byte_q;
    end
    if (cmd_i.copy_step) begin
      abuf_rdata_q <= abuf_mem[dfcq_pkg::AsmIdxW'(cp_idx_q)];
      wr_idx_q     <= cp_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      qmem[wr_addr] <= abuf_rdata_q;
    end
    if (cmd_i.pop_read) begin
      qrdata_q <= qmem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_start) begin
      pop_slot_q <= rp_q;
      pop_len_q  <= head_len;
      pop_copy_q <= dfcq_pkg::FillW'(copy_w);
      pop_idx_q  <= '0;
    end else if (cmd_i.pop_next) begin
      pop_idx_q  <= pop_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_data_q   <= (cmd_i.emit_kind == dfcq_pkg::KIND_BYTE) ? qrdata_q : 8'd0;
      out_len_q    <= (cmd_i.emit_kind == dfcq_pkg::KIND_BYTE ||
                       cmd_i.emit_kind == dfcq_pkg::KIND_ZERO) ? 5'(pop_len_q) : 5'd0;
      out_last_q   <= cmd_i.emit_last;
      out_pstate_q <= pstate_q;
      out_count_q  <= 3'(count_q);
      out_fovf_q   <= fovf_q;
      out_qovf_q   <= qovf_q;
    end
  end

  always_comb begin
    status_o.op          = op_q;
    status_o.is_term     = (byte_q == dfcq_pkg::Terminator);
    status_o.discarding  = disc_q;
    status_o.fill_zero   = (fill_q == '0);
    status_o.fill_full   = (fill_q >= dfcq_pkg::FillW'(dfcq_pkg::FrameLimit));
    status_o.queue_full  = (count_q >= dfcq_pkg::CountW'(dfcq_pkg::QueueDepth));
    status_o.queue_empty = (count_q == '0);
    status_o.copy_zero   = (copy_w == 9'd0);
    status_o.copy_last   = (cp_idx_q == fill_q - 1'b1);
    status_o.pop_last    = (pop_idx_q + 1'b1 == pop_copy_q);
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign data_byte_o       = out_data_q;
  assign cmd_length_o      = out_len_q;
  assign is_last_o         = out_last_q;
  assign parse_state_o     = out_pstate_q;
  assign queue_count_o     = out_count_q;
  assign frame_overflows_o = out_fovf_q;
  assign queue_overflows_o = out_qovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/dfcq_ctrl.sv
// Controller state machine of the frame command queue.
`default_nettype none

module dfcq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dfcq_pkg::dp_status_t status_i,
  output dfcq_pkg::dp_cmd_t         cmd_o
);

  dfcq_pkg::ctrl_state_e state_q, state_d;
  dfcq_pkg::kind_e       kind_q, kind_d;
  logic                  accept;

  assign in_stall_o = (state_q != dfcq_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      dfcq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = dfcq_pkg::ST_EXEC;
        end
      end
      dfcq_pkg::ST_EXEC: begin
        state_d = dfcq_pkg::ST_EMIT;
        kind_d  = dfcq_pkg::KIND_STATUS;
        case (dfcq_pkg::op_e'(status_i.op))
          dfcq_pkg::OP_RX: begin
            if (status_i.is_term && !status_i.discarding && !status_i.fill_zero &&
                !status_i.queue_full) begin
              state_d = dfcq_pkg::ST_COPY;
            end
          end
          dfcq_pkg::OP_POP: begin
            if (status_i.queue_empty) begin
              kind_d = dfcq_pkg::KIND_EMPTY;
            end else if (status_i.copy_zero) begin
              kind_d = dfcq_pkg::KIND_ZERO;
            end else begin
              state_d = dfcq_pkg::ST_POP_RD;
            end
          end
          default: begin
          end
        endcase
      end
      dfcq_pkg::ST_COPY: begin
        if (status_i.copy_last) begin
          state_d = dfcq_pkg::ST_COMMIT;
        end
      end
      dfcq_pkg::ST_COMMIT: begin
        state_d = dfcq_pkg::ST_EMIT;
      end
      dfcq_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = dfcq_pkg::ST_IDLE;
        end
      end
      dfcq_pkg::ST_POP_RD: begin
        state_d = dfcq_pkg::ST_POP_EMIT;
      end
      dfcq_pkg::ST_POP_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.pop_last ? dfcq_pkg::ST_IDLE : dfcq_pkg::ST_POP_RD;
        end
      end
      default: begin
        state_d = dfcq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = kind_q;
    case (state_q)
      dfcq_pkg::ST_IDLE: begin
        cmd_o.latch = accept;
      end
      dfcq_pkg::ST_EXEC: begin
        case (dfcq_pkg::op_e'(status_i.op))
          dfcq_pkg::OP_RX: begin
            if (status_i.is_term) begin
              if (status_i.discarding) begin
                cmd_o.end_discard = 1'b1;
              end else if (!status_i.fill_zero && status_i.queue_full) begin
                cmd_o.drop_frame = 1'b1;
              end
            end else if (!status_i.discarding) begin
              cmd_o.rx_store    = !status_i.fill_full;
              cmd_o.rx_overflow = status_i.fill_full;
            end
          end
          dfcq_pkg::OP_POP: begin
            cmd_o.pop_start = !status_i.queue_empty;
          end
          dfcq_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      dfcq_pkg::ST_COPY: begin
        cmd_o.copy_step = 1'b1;
      end
      dfcq_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      dfcq_pkg::ST_EMIT: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_last = 1'b1;
      end
      dfcq_pkg::ST_POP_RD: begin
        cmd_o.pop_read = 1'b1;
      end
      dfcq_pkg::ST_POP_EMIT: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = dfcq_pkg::KIND_BYTE;
        cmd_o.emit_last = status_i.pop_last;
        cmd_o.pop_next  = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfcq_pkg::ST_IDLE;
      kind_q  <= dfcq_pkg::KIND_STATUS;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/delimited_frame_command_queue_unit.sv
// Top level of the delimited frame command queue.
//
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o  op_i, rx_byte_i, out_limit_i
// result   out        out_valid_o / out_stall_i kind_o, data_byte_o, cmd_length_o, is_last_o,
//                                              parse_state_o, queue_count_o,
//                                              frame_overflows_o, queue_overflows_o
//
// One word is taken at a time. A terminator that queues a frame of n bytes copies them
// one by one through the single read port of the assembly buffer into the queue memory.
// A pop gives one result per copied byte, each fed by the registered queue read.
// Reset clears all control state and both counters; no clearing pass is needed.
// A stalled result holds in the output register, and the next word may already be taken.
`default_nettype none

module delimited_frame_command_queue_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  out_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [4:0]       cmd_length_o,
  output logic             is_last_o,
  output logic [1:0]       parse_state_o,
  output logic [2:0]       queue_count_o,
  output logic [31:0]      frame_overflows_o,
  output logic [31:0]      queue_overflows_o
);

  dfcq_pkg::dp_cmd_t    cmd;
  dfcq_pkg::dp_status_t status;

  dfcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfcq_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op_i),
    .rx_byte_i         (rx_byte_i),
    .out_limit_i       (out_limit_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .cmd_length_o      (cmd_length_o),
    .is_last_o         (is_last_o),
    .parse_state_o     (parse_state_o),
    .queue_count_o     (queue_count_o),
    .frame_overflows_o (frame_overflows_o),
    .queue_overflows_o (queue_overflows_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dfcq_checker.sv
// Port-level checker of the frame command queue and its binding to the top level.
`default_nettype none

module dfcq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] data_byte_o,
  input wire logic [4:0] cmd_length_o,
  input wire logic       is_last_o,
  input wire logic [2:0] queue_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o))
    else $error("stalled result word dropped or changed");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input word taken while the previous one is still in work");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != dfcq_pkg::KIND_BYTE) |-> data_byte_o == 8'd0)
    else $error("data byte set on a word that carries no command byte");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == dfcq_pkg::KIND_STATUS || kind_o == dfcq_pkg::KIND_EMPTY)
    |-> is_last_o && cmd_length_o == 5'd0)
    else $error("status or empty word is not a single word with zero length");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> queue_count_o <= 3'(dfcq_pkg::QueueDepth))
    else $error("queue count exceeds the queue depth");

endmodule

bind delimited_frame_command_queue_unit dfcq_checker u_checker (.*);

`default_nettype wire

// File: sim/dfcq_checker.sv
// Checker for the frame command queue: watches both channels, predicts every result and compares.
`timescale 1ns / 100ps

module dfcq_tb_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  out_limit_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [4:0]  cmd_length_i,
  input  wire logic        is_last_i,
  input  wire logic [1:0]  parse_state_i,
  input  wire logic [2:0]  queue_count_i,
  input  wire logic [31:0] frame_overflows_i,
  input  wire logic [31:0] queue_overflows_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int MaxPrinted = 200;

  typedef struct {
    dfcq_pkg::kind_e        kind;
    logic [7:0]             data;
    logic [4:0]             len;
    logic                   last;
    dfcq_pkg::parse_state_e pstate;
    logic [2:0]             count;
    logic [31:0]            frame_ovf;
    logic [31:0]            queue_ovf;
  } queue_result_t;

  queue_result_t due_results[$];

  logic [7:0]             asm_bytes[dfcq_pkg::AsmBytes];
  logic [7:0]             slot_bytes[dfcq_pkg::QmemDepth];
  logic [4:0]             slot_len[dfcq_pkg::QueueDepth];
  int                     fill;
  bit                     discarding;
  dfcq_pkg::parse_state_e pstate;
  int                     rd_slot;
  int                     wr_slot;
  int                     waiting;
  logic [31:0]            frame_ovf_total;
  logic [31:0]            queue_ovf_total;
  int                     words_seen;

  task automatic report_fault(input string msg);
    if (fail_count_o < MaxPrinted) begin
      $display("ERROR %0t ns: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  function automatic void queue_result(dfcq_pkg::kind_e k, logic [7:0] d, logic [4:0] l,
                                       logic last);
    queue_result_t r;
    r.kind      = k;
    r.data      = d;
    r.len       = l;
    r.last      = last;
    r.pstate    = pstate;
    r.count     = waiting[2:0];
    r.frame_ovf = frame_ovf_total;
    r.queue_ovf = queue_ovf_total;
    due_results.push_back(r);
  endfunction

  function automatic void settle_after_frame();
    if (waiting > 0) begin
      pstate = dfcq_pkg::PS_PENDING;
    end else begin
      pstate = dfcq_pkg::PS_IDLE;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (b == dfcq_pkg::Terminator) begin
      if (discarding) begin
        fill       = 0;
        discarding = 1'b0;
        settle_after_frame();
      end else if (fill > 0) begin
        if (waiting >= dfcq_pkg::QueueDepth) begin
          queue_ovf_total++;
        end else begin
          for (int i = 0; i < fill; i++) begin
            slot_bytes[wr_slot * dfcq_pkg::MaxCmdLen + i] = asm_bytes[i];
          end
          slot_len[wr_slot] = fill[4:0];
          wr_slot = (wr_slot + 1) % dfcq_pkg::QueueDepth;
          waiting++;
          pstate = dfcq_pkg::PS_PENDING;
        end
        fill = 0;
      end
    end else if (!discarding) begin
      if (fill < dfcq_pkg::FrameLimit) begin
        asm_bytes[fill] = b;
        fill++;
      end else begin
        fill       = 0;
        discarding = 1'b1;
        frame_ovf_total++;
      end
      pstate = dfcq_pkg::PS_RECEIVING;
    end
  endfunction

  function automatic void pop_command(logic [7:0] lim);
    int slot;
    int len;
    int copy;
    if (waiting == 0) begin
      queue_result(dfcq_pkg::KIND_EMPTY, 8'h00, 5'd0, 1'b1);
      return;
    end
    slot = rd_slot;
    len  = slot_len[slot];
    copy = 0;
    if (lim > 0) begin
      copy = (len >= lim) ? lim - 1 : len;
    end
    if (copy > dfcq_pkg::ResultCap) copy = dfcq_pkg::ResultCap;
    slot_len[slot] = 5'd0;
    rd_slot = (slot + 1) % dfcq_pkg::QueueDepth;
    waiting--;
    settle_after_frame();
    if (copy == 0) begin
      queue_result(dfcq_pkg::KIND_ZERO, 8'h00, len[4:0], 1'b1);
    end else begin
      for (int i = 0; i < copy; i++) begin
        queue_result(dfcq_pkg::KIND_BYTE, slot_bytes[slot * dfcq_pkg::MaxCmdLen + i],
                     len[4:0], i + 1 == copy);
      end
    end
  endfunction

  function automatic void step_frame_queue(logic [1:0] op, logic [7:0] b, logic [7:0] lim);
    case (op)
      dfcq_pkg::OP_POP: begin
        pop_command(lim);
      end
      dfcq_pkg::OP_RX: begin
        take_byte(b);
        queue_result(dfcq_pkg::KIND_STATUS, 8'h00, 5'd0, 1'b1);
      end
      dfcq_pkg::OP_CLEAR: begin
        fill       = 0;
        rd_slot    = 0;
        wr_slot    = 0;
        waiting    = 0;
        discarding = 1'b0;
        pstate     = dfcq_pkg::PS_IDLE;
        queue_result(dfcq_pkg::KIND_STATUS, 8'h00, 5'd0, 1'b1);
      end
      default: begin
        queue_result(dfcq_pkg::KIND_STATUS, 8'h00, 5'd0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      due_results.delete();
      for (int i = 0; i < dfcq_pkg::AsmBytes; i++) asm_bytes[i] = 8'h00;
      for (int i = 0; i < dfcq_pkg::QmemDepth; i++) slot_bytes[i] = 8'h00;
      for (int i = 0; i < dfcq_pkg::QueueDepth; i++) slot_len[i] = 5'd0;
      fill            = 0;
      discarding      = 1'b0;
      pstate          = dfcq_pkg::PS_IDLE;
      rd_slot         = 0;
      wr_slot         = 0;
      waiting         = 0;
      frame_ovf_total = '0;
      queue_ovf_total = '0;
      words_seen      = 0;
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        step_frame_queue(op_i, rx_byte_i, out_limit_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_fault($sformatf("result word %0d arrived with nothing expected", words_seen));
        end else begin
          want = due_results.pop_front();
          if (kind_i !== want.kind)
            report_fault($sformatf("word %0d kind %0d, expected %0d",
                                   words_seen, kind_i, want.kind));
          if (data_byte_i !== want.data)
            report_fault($sformatf("word %0d data_byte %0h, expected %0h",
                                   words_seen, data_byte_i, want.data));
          if (cmd_length_i !== want.len)
            report_fault($sformatf("word %0d cmd_length %0d, expected %0d",
                                   words_seen, cmd_length_i, want.len));
          if (is_last_i !== want.last)
            report_fault($sformatf("word %0d is_last %0b, expected %0b",
                                   words_seen, is_last_i, want.last));
          if (parse_state_i !== want.pstate)
            report_fault($sformatf("word %0d parse_state %0d, expected %0d",
                                   words_seen, parse_state_i, want.pstate));
          if (queue_count_i !== want.count)
            report_fault($sformatf("word %0d queue_count %0d, expected %0d",
                                   words_seen, queue_count_i, want.count));
          if (frame_overflows_i !== want.frame_ovf)
            report_fault($sformatf("word %0d frame_overflows %0d, expected %0d",
                                   words_seen, frame_overflows_i, want.frame_ovf));
          if (queue_overflows_i !== want.queue_ovf)
            report_fault($sformatf("word %0d queue_overflows %0d, expected %0d",
                                   words_seen, queue_overflows_i, want.queue_ovf));
        end
        words_seen++;
      end
      pending_o = due_results.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the frame command queue: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int         RandomWords = 380;
  localparam int         CycleLimit  = 1000000;
  localparam int         TailCycles  = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [7:0]  rx_byte_i;
  logic [7:0]  out_limit_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [4:0]  cmd_length_o;
  logic        is_last_o;
  logic [1:0]  parse_state_o;
  logic [2:0]  queue_count_o;
  logic [31:0] frame_overflows_o;
  logic [31:0] queue_overflows_o;
  int          fail_count;
  int          pending;
  int          words_sent;
  int          cycles;
  int          send_run;
  bit          send_calm;
  int          sink_run;
  bit          sink_calm;

  always #1 clk_i = ~clk_i;

  delimited_frame_command_queue_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .rx_byte_i         (rx_byte_i),
    .out_limit_i       (out_limit_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .cmd_length_o      (cmd_length_o),
    .is_last_o         (is_last_o),
    .parse_state_o     (parse_state_o),
    .queue_count_o     (queue_count_o),
    .frame_overflows_o (frame_overflows_o),
    .queue_overflows_o (queue_overflows_o)
  );

  dfcq_tb_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .op_i              (op_i),
    .rx_byte_i         (rx_byte_i),
    .out_limit_i       (out_limit_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_i            (kind_o),
    .data_byte_i       (data_byte_o),
    .cmd_length_i      (cmd_length_o),
    .is_last_i         (is_last_o),
    .parse_state_i     (parse_state_o),
    .queue_count_i     (queue_count_o),
    .frame_overflows_i (frame_overflows_o),
    .queue_overflows_i (queue_overflows_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Idle gaps come in stretches, some of which have no gaps at all.
  function automatic int draw_wait(ref int run_left, ref bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [7:0] lim);
    int gap;
    gap = draw_wait(send_run, send_calm);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    rx_byte_i   <= b;
    out_limit_i <= lim;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [7:0] frame_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == dfcq_pkg::Terminator);
    return b;
  endfunction

  task automatic send_frame(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_word(dfcq_pkg::OP_RX, frame_byte(), 8'($urandom_range(0, 255)));
    end
    if (closed) send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_pop();
    logic [7:0] lim;
    case ($urandom_range(0, 5))
      0:       lim = 8'd0;
      1:       lim = 8'd1;
      2:       lim = 8'($urandom_range(2, 8));
      3:       lim = 8'd255;
      default: lim = 8'($urandom_range(0, 255));
    endcase
    send_word(dfcq_pkg::OP_POP, 8'($urandom_range(0, 255)), lim);
  endtask

  task automatic send_random_mix();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      case ($urandom_range(0, 19))
        0:              len = 0;
        1, 2:           len = $urandom_range(dfcq_pkg::FrameLimit, dfcq_pkg::FrameLimit + 2);
        3, 4, 5:        len = $urandom_range(9, dfcq_pkg::FrameLimit - 1);
        default:        len = $urandom_range(1, 8);
      endcase
      send_frame(len, 1'b1);
    end else if (pick < 80) begin
      send_pop();
    end else if (pick < 87) begin
      send_frame($urandom_range(1, 6), 1'b0);
    end else if (pick < 93) begin
      send_word(dfcq_pkg::OP_RX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_word(dfcq_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      send_word(OpUnused, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int n;
    out_stall_i = 1'b0;
    sink_run    = 0;
    forever begin
      n = draw_wait(sink_run, sink_calm);
      if (n != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int goal;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = dfcq_pkg::OP_RX;
    rx_byte_i   = 8'h00;
    out_limit_i = 8'h00;
    words_sent  = 0;
    send_run    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd255);
    send_word(OpUnused, 8'hff, 8'hff);
    send_word(dfcq_pkg::OP_CLEAR, 8'h00, 8'h00);
    send_word(dfcq_pkg::OP_RX, 8'h00, 8'h00);
    send_word(dfcq_pkg::OP_RX, 8'hff, 8'hff);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd255);
    send_word(dfcq_pkg::OP_RX, 8'h41, 8'h00);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd1);
    send_word(dfcq_pkg::OP_RX, 8'h42, 8'h00);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd0);
    send_word(dfcq_pkg::OP_RX, 8'h43, 8'h00);
    send_word(dfcq_pkg::OP_RX, 8'h44, 8'h00);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd2);
    send_word(dfcq_pkg::OP_RX, 8'h45, 8'h00);
    send_word(dfcq_pkg::OP_RX, dfcq_pkg::Terminator, 8'h00);
    send_word(dfcq_pkg::OP_CLEAR, 8'h00, 8'h00);
    send_word(dfcq_pkg::OP_POP, 8'h00, 8'd255);

    // The longest frame that fits, then one that overflows by a single byte.
    goal = RandomWords;
    send_frame(dfcq_pkg::FrameLimit, 1'b1);
    send_word(dfcq_pkg::OP_POP, 8'($urandom_range(0, 255)), 8'd255);
    send_frame(dfcq_pkg::FrameLimit + 1, 1'b1);
    while (words_sent < goal - RandomWords / 2) send_random_mix();
    drain_results();
    while (words_sent < goal) send_random_mix();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
